// ----- design/sso_pkg.sv -----
// Shared types, constants and tables of the skid-steer odometry core.
// No dependencies.
package sso_pkg;

    localparam int     CORDIC_STEPS_DEF = 24;
    localparam int     MUL_W            = 34;
    localparam int     PROD_W           = 2 * MUL_W;
    localparam int     FIX_STEPS        = 4;
    localparam int     CNT_W            = 6;
    localparam int     MICRO            = 1000000;
    localparam int     HALF_MICRO       = 500000;
    localparam longint RECIP_MICRO      = 64'd4503599627;
    localparam int     PI30_Q24         = 1756906;
    localparam int     INV2PI_Q32       = 683565276;
    localparam int     CORDIC_GAIN      = 652032874;

    typedef enum logic [2:0] {
        REG_MODE          = 3'd0,
        REG_GEAR_RATIO    = 3'd1,
        REG_RADIUS        = 3'd2,
        REG_INV_BASELINE  = 3'd3,
        REG_START_X       = 3'd4,
        REG_START_Y       = 3'd5,
        REG_START_HEADING = 3'd6
    } reg_index_t;

    typedef enum logic [4:0] {
        S_IDLE, S_K1, S_K2, S_KQ, S_LIN, S_T, S_TQ, S_ANG, S_AQ, S_MD, S_MA,
        S_DV0, S_QA, S_QB, S_RA, S_RB, S_DIV, S_DSGN, S_TURN, S_PHI, S_CORD,
        S_PX, S_PY, S_PW, S_OUT
    } state_t;

    typedef struct packed {
        logic signed [15:0] rpm_front_right;
        logic signed [15:0] rpm_front_left;
        logic signed [15:0] rpm_rear_right;
        logic signed [15:0] rpm_rear_left;
        logic        [19:0] elapsed_us;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic        [31:0] pose_heading;
        logic signed [31:0] linear_speed;
        logic signed [31:0] angular_speed;
    } out_word_t;

    function automatic logic [31:0] atan_at(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ----- design/sso_mul.sv -----
// Shared signed multiplier with registered product.
// Depends on sso_pkg.
module sso_mul #(
    parameter int W = sso_pkg::MUL_W
) (
    input  logic                  clk,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p_reg
);

    logic signed [2*W-1:0] p_next;

    assign p_next = (2*W)'(a) * (2*W)'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

endmodule

// ----- design/skid_steer_odometry_core.sv -----
// Skid-steer odometry: wheel speeds to body speeds, pose integration via CORDIC.
// Depends on sso_pkg and sso_mul.
// The input word runs through the shared multiplier sequence, a reciprocal divide with 4 fix-up steps and the CORDIC.
// One word at a time, taken only while idle; an unaccepted result
// holds the sequencer, next word taken the cycle after the result is latched.
// Reset: async active low; config to defaults, pose to zero, no word pending.
module skid_steer_odometry_core #(
    parameter int CORDIC_STEPS = sso_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sso_pkg::in_word_t    in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sso_pkg::out_word_t   out_word,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int MW = sso_pkg::MUL_W;
    localparam int PW = sso_pkg::PROD_W;

    typedef logic [sso_pkg::CNT_W-1:0] cnt_t;

    function automatic logic signed [PW-1:0] rsh(input logic signed [PW-1:0] v, input int s);
        logic signed [PW-1:0] t;
        t = v + (PW'(1) <<< (s - 1));
        return t >>> s;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [PW-1:0] v);
        logic [31:0] r;
        if (v > PW'(64'sh7FFFFFFF))
            r = 32'h7FFFFFFF;
        else if (v < -PW'(64'sh80000000))
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    sso_pkg::state_t state_reg, state_next;

    logic                mode_reg;
    logic [15:0]         gear_reg, radius_reg;
    logic [23:0]         ib_reg;
    logic [31:0]         px_reg, px_next, py_reg, py_next, hd_reg, hd_next;
    logic [sso_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    logic signed [17:0]  diff_reg, sum_reg;
    logic [19:0]         dt_reg;
    logic [28:0]         kq_reg;
    logic [31:0]         lin_reg, ang_reg;
    logic signed [33:0]  t_reg;
    logic [51:0]         dvd_a_reg, dvd_b_reg;
    logic [22:0]         rem_a_reg, rem_b_reg;
    logic [32:0]         q_a_reg, q_b_reg;
    logic                neg_a_reg, neg_b_reg;
    logic signed [32:0]  dist_reg, dth_reg;
    logic [31:0]         turn_reg;
    logic signed [33:0]  x_reg, y_reg, z_reg;
    logic                flip_reg;
    sso_pkg::out_word_t  out_reg;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] p_reg;
    logic signed [PW-1:0] p_abs;
    logic signed [PW-1:0] p_r16, p_r17, p_r21, p_r22, p_r24, p_r30;
    logic [51:0]          mag;
    logic                 ge_a, ge_b;
    logic [4:0]           idx;
    logic signed [33:0]   xs, ys, atan_v, cx, sy;
    logic [31:0]          half_v, phi, phi_f;
    logic                 flip_v;
    logic signed [16:0]   sr, sl;

    sso_mul #(.W(MW)) u_mul (
        .clk   (clk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (p_reg)
    );

    assign in_ready  = (state_reg == sso_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    assign sr = 17'(in_word.rpm_front_right) + 17'(in_word.rpm_rear_right);
    assign sl = 17'(in_word.rpm_front_left) + 17'(in_word.rpm_rear_left);

    assign p_r16 = rsh(p_reg, 16);
    assign p_r17 = rsh(p_reg, 17);
    assign p_r21 = rsh(p_reg, 21);
    assign p_r22 = rsh(p_reg, 22);
    assign p_r24 = rsh(p_reg, 24);
    assign p_r30 = rsh(p_reg, 30);

    // rounded magnitude, then quotient estimate by reciprocal and fix-up
    assign p_abs   = p_reg[PW-1] ? -p_reg : p_reg;
    assign mag     = p_abs[51:0] + 52'(sso_pkg::HALF_MICRO);
    assign ge_a    = rem_a_reg >= 23'(sso_pkg::MICRO);
    assign ge_b    = rem_b_reg >= 23'(sso_pkg::MICRO);

    assign idx    = cnt_reg[4:0];
    assign xs     = x_reg >>> idx;
    assign ys     = y_reg >>> idx;
    assign atan_v = {2'b00, sso_pkg::atan_at(idx)};
    assign cx     = flip_reg ? -x_reg : x_reg;
    assign sy     = flip_reg ? -y_reg : y_reg;

    assign half_v = p_r17[31:0];
    assign phi    = hd_reg + (mode_reg ? half_v : 32'd0);
    assign flip_v = phi[31] ^ phi[30];
    assign phi_f  = phi ^ {flip_v, 31'd0};

    // operand select, sequencer, pose update and start-pose writes
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        hd_next        = hd_reg;
        mul_a          = '0;
        mul_b          = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            sso_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = sso_pkg::S_K1;
            end
            sso_pkg::S_K1:
            begin
                mul_a = {18'd0, gear_reg};
                mul_b = {18'd0, radius_reg};
                state_next = sso_pkg::S_K2;
            end
            sso_pkg::S_K2:
            begin
                mul_a = {2'b00, p_reg[31:0]};
                mul_b = MW'(sso_pkg::PI30_Q24);
                state_next = sso_pkg::S_KQ;
            end
            sso_pkg::S_KQ:  state_next = sso_pkg::S_LIN;
            sso_pkg::S_LIN:
            begin
                mul_a = MW'(diff_reg);
                mul_b = {5'd0, kq_reg};
                state_next = sso_pkg::S_T;
            end
            sso_pkg::S_T:
            begin
                mul_a = MW'(sum_reg);
                mul_b = {5'd0, kq_reg};
                state_next = sso_pkg::S_TQ;
            end
            sso_pkg::S_TQ:  state_next = sso_pkg::S_ANG;
            sso_pkg::S_ANG:
            begin
                mul_a = t_reg;
                mul_b = {10'd0, ib_reg};
                state_next = sso_pkg::S_AQ;
            end
            sso_pkg::S_AQ:  state_next = sso_pkg::S_MD;
            sso_pkg::S_MD:
            begin
                mul_a = MW'($signed(lin_reg));
                mul_b = {14'd0, dt_reg};
                state_next = sso_pkg::S_MA;
            end
            sso_pkg::S_MA:
            begin
                mul_a = MW'($signed(ang_reg));
                mul_b = {14'd0, dt_reg};
                state_next = sso_pkg::S_DV0;
            end
            sso_pkg::S_DV0:
            begin
                mul_a = {2'b00, dvd_a_reg[51:20]};
                mul_b = MW'(sso_pkg::RECIP_MICRO);
                state_next = sso_pkg::S_QA;
            end
            sso_pkg::S_QA:
            begin
                mul_a = {2'b00, dvd_b_reg[51:20]};
                mul_b = MW'(sso_pkg::RECIP_MICRO);
                state_next = sso_pkg::S_QB;
            end
            sso_pkg::S_QB:
            begin
                mul_a = {1'b0, q_a_reg};
                mul_b = MW'(sso_pkg::MICRO);
                state_next = sso_pkg::S_RA;
            end
            sso_pkg::S_RA:
            begin
                mul_a = {1'b0, q_b_reg};
                mul_b = MW'(sso_pkg::MICRO);
                state_next = sso_pkg::S_RB;
            end
            sso_pkg::S_RB:
            begin
                cnt_next   = '0;
                state_next = sso_pkg::S_DIV;
            end
            sso_pkg::S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == cnt_t'(sso_pkg::FIX_STEPS - 1))
                    state_next = sso_pkg::S_DSGN;
            end
            sso_pkg::S_DSGN: state_next = sso_pkg::S_TURN;
            sso_pkg::S_TURN:
            begin
                mul_a = MW'(dth_reg);
                mul_b = MW'(sso_pkg::INV2PI_Q32);
                state_next = sso_pkg::S_PHI;
            end
            sso_pkg::S_PHI:
            begin
                cnt_next   = '0;
                state_next = sso_pkg::S_CORD;
            end
            sso_pkg::S_CORD:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == cnt_t'(CORDIC_STEPS - 1))
                    state_next = sso_pkg::S_PX;
            end
            sso_pkg::S_PX:
            begin
                mul_a = MW'(dist_reg);
                mul_b = cx;
                state_next = sso_pkg::S_PY;
            end
            sso_pkg::S_PY:
            begin
                mul_a = MW'(dist_reg);
                mul_b = sy;
                px_next = px_reg + p_r30[31:0];
                state_next = sso_pkg::S_PW;
            end
            sso_pkg::S_PW:
            begin
                py_next = py_reg + p_r30[31:0];
                hd_next = hd_reg + turn_reg;
                state_next = sso_pkg::S_OUT;
            end
            sso_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = sso_pkg::S_IDLE;
                end
            end
            default: state_next = sso_pkg::S_IDLE;
        endcase
        if (cfg_we)
        begin
            case (cfg_index)
                sso_pkg::REG_START_X:       px_next = cfg_data;
                sso_pkg::REG_START_Y:       py_next = cfg_data;
                sso_pkg::REG_START_HEADING: hd_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sso_pkg::S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            px_reg        <= '0;
            py_reg        <= '0;
            hd_reg        <= '0;
            mode_reg      <= 1'b0;
            gear_reg      <= 16'd65535;
            radius_reg    <= 16'd10000;
            ib_reg        <= 24'd65536;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            hd_reg        <= hd_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    sso_pkg::REG_MODE:         mode_reg   <= cfg_data[0];
                    sso_pkg::REG_GEAR_RATIO:   gear_reg   <= cfg_data[15:0];
                    sso_pkg::REG_RADIUS:       radius_reg <= cfg_data[15:0];
                    sso_pkg::REG_INV_BASELINE: ib_reg     <= cfg_data[23:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            sso_pkg::S_IDLE:
            begin
                diff_reg <= 18'(sr) - 18'(sl);
                sum_reg  <= 18'(sr) + 18'(sl);
                dt_reg   <= in_word.elapsed_us;
            end
            sso_pkg::S_KQ:  kq_reg  <= p_r24[28:0];
            sso_pkg::S_T:   lin_reg <= sat32(p_r22);
            sso_pkg::S_TQ:  t_reg   <= p_r16[33:0];
            sso_pkg::S_AQ:  ang_reg <= sat32(p_r21);
            sso_pkg::S_MA:
            begin
                dvd_a_reg <= mag;
                neg_a_reg <= p_reg[PW-1];
            end
            sso_pkg::S_DV0:
            begin
                dvd_b_reg <= mag;
                neg_b_reg <= p_reg[PW-1];
            end
            sso_pkg::S_QA:  q_a_reg <= p_reg[64:32];
            sso_pkg::S_QB:  q_b_reg <= p_reg[64:32];
            sso_pkg::S_RA:  rem_a_reg <= 23'(dvd_a_reg - p_reg[51:0]);
            sso_pkg::S_RB:  rem_b_reg <= 23'(dvd_b_reg - p_reg[51:0]);
            sso_pkg::S_DIV:
            begin
                rem_a_reg <= ge_a ? rem_a_reg - 23'(sso_pkg::MICRO) : rem_a_reg;
                rem_b_reg <= ge_b ? rem_b_reg - 23'(sso_pkg::MICRO) : rem_b_reg;
                q_a_reg   <= q_a_reg + 33'(ge_a);
                q_b_reg   <= q_b_reg + 33'(ge_b);
            end
            sso_pkg::S_DSGN:
            begin
                dist_reg <= neg_a_reg ? -$signed(q_a_reg) : $signed(q_a_reg);
                dth_reg  <= neg_b_reg ? -$signed(q_b_reg) : $signed(q_b_reg);
            end
            sso_pkg::S_PHI:
            begin
                turn_reg <= p_r16[31:0];
                flip_reg <= flip_v;
                x_reg    <= 34'(sso_pkg::CORDIC_GAIN);
                y_reg    <= '0;
                z_reg    <= 34'($signed(phi_f));
            end
            sso_pkg::S_CORD:
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_v;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_v;
                end
            end
            sso_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_reg.pose_x        <= px_reg;
                    out_reg.pose_y        <= py_reg;
                    out_reg.pose_heading  <= hd_reg;
                    out_reg.linear_speed  <= lin_reg;
                    out_reg.angular_speed <= ang_reg;
                end
            end
            default: ;
        endcase
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sso_pkg::S_DIV |-> cnt_reg < cnt_t'(sso_pkg::FIX_STEPS))
        else $error("divide fix-up counter overrun");

    a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sso_pkg::S_CORD |-> cnt_reg < cnt_t'(CORDIC_STEPS))
        else $error("cordic counter overrun");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == sso_pkg::S_OUT))
        else $error("result word without finished item");

    a_heading_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sso_pkg::S_IDLE && !cfg_we |=> $stable(hd_reg))
        else $error("heading moved while idle");

endmodule
